/* rtl/mts_pkg.sv */
`default_nettype none

package mts_pkg;

    // Stream payload widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int CAP_W       = 9;
    localparam int TOTAL_W     = 9;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Command codes; any other code reads the state only
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic fetch;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_ok;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/mts_ctrl.sv */
`default_nettype none

module mts_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output mts_pkg::ctrl_cmd_t  cmd,
    input  mts_pkg::dp_status_t status
);

    mts_pkg::state_t state_reg;
    mts_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mts_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            mts_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = mts_pkg::ST_EXEC;
                end
            end
            mts_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.pop_ok ? mts_pkg::ST_FETCH : mts_pkg::ST_RESP;
            end
            mts_pkg::ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = mts_pkg::ST_RESP;
            end
            mts_pkg::ST_RESP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mts_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/mts_datapath.sv */
`default_nettype none

module mts_datapath #(
    parameter int DEPTH = 256
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire  [mts_pkg::IN_TDATA_W-1:0]        in_value,
    input  wire  [mts_pkg::IN_TUSER_W-1:0]        in_command,
    input  wire                                   cfg_wr_en,
    input  wire  [mts_pkg::CAP_W-1:0]             cfg_wr_data,
    input  mts_pkg::ctrl_cmd_t                    cmd,
    output mts_pkg::dp_status_t                   status,
    output logic [mts_pkg::OUT_TDATA_W-1:0]       out_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > mts_pkg::CAP_W) ? CW : mts_pkg::CAP_W;
    localparam int PADW = mts_pkg::OUT_TDATA_W - 76;

    logic        [31:0]                 value_mem [DEPTH];
    logic        [31:0]                 min_mem   [DEPTH];

    logic        [1:0]                  cmd_reg;
    logic signed [31:0]                 val_reg;
    logic        [mts_pkg::CAP_W-1:0]   cap_reg;
    logic        [CW-1:0]               count_reg;
    logic        [CW-1:0]               count_next;
    logic        [CW-1:0]               min_count_reg;
    logic        [CW-1:0]               min_count_next;
    logic signed [31:0]                 top_val_reg;
    logic signed [31:0]                 min_top_reg;
    logic        [1:0]                  status_reg;
    logic        [mts_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic          is_push;
    logic          is_pop;
    logic          full;
    logic          push_ok;
    logic          pop_ok;
    logic          to_min;
    logic          min_pop;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] min_dec;
    logic          empty;

    assign is_push = (cmd_reg == mts_pkg::CMD_PUSH);
    assign is_pop  = (cmd_reg == mts_pkg::CMD_POP);
    assign full    = (CMPW'(count_reg) >= CMPW'(cap_reg)) || (count_reg == CW'(DEPTH));
    assign push_ok = is_push && !full;
    assign pop_ok  = is_pop && (count_reg != '0);
    assign to_min  = (min_count_reg == '0) || (val_reg <= min_top_reg);
    assign min_pop = (min_count_reg != '0) && (min_top_reg == top_val_reg);
    assign cnt_dec = count_reg - CW'(1);
    assign min_dec = min_count_reg - CW'(1);
    assign empty   = (count_reg == '0);

    assign status.pop_ok = pop_ok;

    always_comb
    begin
        count_next     = count_reg;
        min_count_next = min_count_reg;
        if (cmd.exec && push_ok)
        begin
            count_next = count_reg + CW'(1);
            if (to_min)
            begin
                min_count_next = min_count_reg + CW'(1);
            end
        end
        else if (cmd.exec && pop_ok)
        begin
            count_next = cnt_dec;
            if (min_pop)
            begin
                min_count_next = min_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= mts_pkg::CAP_RESET;
            count_reg     <= '0;
            min_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            min_count_reg <= min_count_next;
        end
    end

    // Stores and top-of-stack registers; reads land straight in the top registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg <= in_command;
            val_reg <= in_value;
        end
        if (cmd.exec)
        begin
            if (is_push)
            begin
                status_reg <= full ? mts_pkg::STAT_FULL : mts_pkg::STAT_OK;
            end
            else if (is_pop)
            begin
                status_reg <= pop_ok ? mts_pkg::STAT_OK : mts_pkg::STAT_EMPTY;
            end
            else
            begin
                status_reg <= mts_pkg::STAT_OK;
            end
        end
        if (cmd.exec && push_ok)
        begin
            value_mem[count_reg[AW-1:0]] <= val_reg;
            top_val_reg                  <= val_reg;
            if (to_min)
            begin
                min_mem[min_count_reg[AW-1:0]] <= val_reg;
                min_top_reg                    <= val_reg;
            end
        end
        if (cmd.fetch)
        begin
            top_val_reg <= value_mem[cnt_dec[AW-1:0]];
            min_top_reg <= min_mem[min_dec[AW-1:0]];
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {
                {PADW{1'b0}},
                status_reg,
                empty,
                mts_pkg::TOTAL_W'(count_reg),
                empty ? 32'd0 : min_top_reg,
                empty ? 32'd0 : top_val_reg
            };
        end
    end

    assign out_data = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_min_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        min_count_reg <= count_reg)
        else $error("minimum stack deeper than value stack");

    a_min_present: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_count_reg != '0))
        else $error("entries held but minimum stack empty");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && push_ok) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted push did not advance the count");

endmodule

`default_nettype wire

/* rtl/min_tracking_stack.sv */
// min_tracking_stack: LIFO of signed 32-bit values that also reports the
// least value held.
// Input stream: s_tuser carries the command (push, pop, read; the unused
// code reads), s_tdata the value to push. Output stream: one beat per input
// beat with top, minimum, entry count, empty flag and status.
// Configuration: cfg_wr_en writes the capacity limit (reset 256); the user
// is to write it only while idle, which the block itself does not enforce;
// pushes are refused once the count reaches it or DEPTH.
// Sequencing: an accepted beat passes through execute and respond steps, and
// a successful pop adds one step that reads the new top entry back from the
// value and minimum memories into registers. The respond step loads the
// output register, and the single-item controller takes the next beat
// only once it is back in idle.
// Reset empties both stacks at once (count registers only, no clearing pass).
// Stall: a result waits in the output register; the next beat is still
// accepted and processed, and its result holds in the respond step until
// the waiting beat is taken.
`default_nettype none

module min_tracking_stack #(
    parameter int DEPTH = 256
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // s_tdata: value[31:0]
    input  wire  [mts_pkg::IN_TDATA_W-1:0]        s_tdata,
    // s_tuser: command[1:0]
    input  wire  [mts_pkg::IN_TUSER_W-1:0]        s_tuser,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // m_tdata: top_value[31:0], min_value[63:32], entry_total[72:64],
    //          is_empty[73], status[75:74], zero pad[79:76]
    output logic [mts_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    input  wire                                   cfg_wr_en,
    input  wire  [mts_pkg::CAP_W-1:0]             cfg_wr_data
);

    mts_pkg::ctrl_cmd_t  cmd;
    mts_pkg::dp_status_t dp_status;

    // Sequence each beat: latch, execute, optional fetch, respond
    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (dp_status)
    );

    // Hold both stacks, their counts and the top registers
    mts_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_value    (s_tdata),
        .in_command  (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (dp_status),
        .out_data    (m_tdata)
    );

endmodule

`default_nettype wire
